/* rtl/core/pap_pkg.sv */
// Shared constants and types for the polygon area and perimeter unit.
`default_nettype none

package pap_pkg;

    // Default geometry of the datapath.
    localparam int COORD_BITS_DEF    = 16;
    localparam int FRACTION_BITS_DEF = 8;

    // Fixed widths of the accumulators and result fields.
    localparam int AREA_ACC_BITS = 48;
    localparam int AREA_OUT_BITS = 34;
    localparam int LEN_BITS      = 35;

    localparam logic [AREA_OUT_BITS-1:0] AREA_OUT_MAX = '1;
    localparam logic [LEN_BITS-1:0]      LEN_MAX      = '1;

    typedef logic signed [AREA_ACC_BITS-1:0] t_area;
    typedef logic [LEN_BITS-1:0]             t_len;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQX,
        S_SQY,
        S_TERM,
        S_LOAD,
        S_ROOT,
        S_ACC,
        S_CLOSE,
        S_CSUM,
        S_FINAL
    } t_state;

endpackage

`default_nettype wire

/* rtl/core/polygon_area_perimeter_unit.sv */
// Top level of the polygon area and perimeter unit.
`default_nettype none

// The unit takes polygon vertices one request at a time and, on the request
// that carries last_vertex, returns one result: twice the absolute enclosed
// area (shoelace sum including the closing edge, saturated to 34 bits) and
// the open-polyline perimeter in fixed point with FRACTION_BITS fraction
// bits, saturating at 2^35-1, with a flag that marks saturation. A vertex
// that opens a polygon is absorbed in its accept cycle, and unless it also
// carries last_vertex the unit is ready again at once. Every further vertex
// runs through one shared signed multiplier (dx squared, dy squared, then the
// area term) and then through a restoring square root that yields one root
// bit per cycle, so it holds off new requests while it passes S_SQX, S_SQY,
// S_TERM, S_LOAD, the square root loop of COORD_BITS + 1 + FRACTION_BITS
// steps in S_ROOT, and S_ACC. The last vertex adds S_CLOSE and S_CSUM for
// the closing area term and S_FINAL for the result. The result sits in
// an output register, and the unit takes new vertices while it waits to
// be taken; only a second result that finds the register still full waits.

module polygon_area_perimeter_unit
    import pap_pkg::*;
#(
    parameter int COORD_BITS    = COORD_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,

    input  wire                          i_in_valid,
    output logic                         o_in_stall,
    input  wire signed [COORD_BITS-1:0]  i_vertex_x,
    input  wire signed [COORD_BITS-1:0]  i_vertex_y,
    input  wire                          i_last_vertex,

    output logic                         o_out_valid,
    input  wire                          i_out_stall,
    output logic [AREA_OUT_BITS-1:0]     o_area_doubled,
    output logic [LEN_BITS-1:0]          o_perimeter_fixed,
    output logic                         o_perimeter_saturated
);

    // Differences and sums of two coordinates need one extra bit.
    localparam int CW1  = COORD_BITS + 1;
    // Product width; also the width of dx*dx + dy*dy.
    localparam int PW   = 2 * CW1;
    // Root bits: one per radicand pair plus the fraction bits.
    localparam int NR   = CW1 + FRACTION_BITS;
    localparam int RADW = 2 * NR;
    // The partial remainder stays below 2^(NR+1); the shifted one needs two more bits.
    localparam int RW   = NR + 3;
    localparam int SUMW = ((NR > LEN_BITS) ? NR : LEN_BITS) + 1;
    localparam int CNTW = $clog2(NR);
    localparam logic [CNTW-1:0] CNT_LAST = CNTW'(NR - 1);

    t_state r_state, n_state;

    // Vertex registers.
    logic signed [COORD_BITS-1:0] r_first_x, r_first_y;
    logic signed [COORD_BITS-1:0] r_prev_x, r_prev_y;
    logic signed [COORD_BITS-1:0] r_cur_x, r_cur_y;
    logic                         r_cur_last;
    logic                         r_have_vertex;

    // Arithmetic registers.
    logic signed [PW-1:0]   r_prod;
    logic [PW-1:0]          r_d2;
    logic [RADW-1:0]        r_rad;
    logic [NR-1:0]          r_root;
    logic [RW-1:0]          r_rem;
    logic [CNTW-1:0]        r_cnt;
    t_area                  r_area_sum;
    t_len                   r_length_sum;

    // Output register.
    logic                     r_out_valid;
    logic [AREA_OUT_BITS-1:0] r_area_out;
    t_len                     r_len_out;

    // Combinational helpers.
    logic                 in_accept;
    logic                 out_free;
    logic signed [CW1-1:0] mul_a, mul_b;
    logic signed [PW-1:0]  mul_p;
    logic [RW-1:0]        rem_sh;
    logic [RW-1:0]        trial;
    logic [RW:0]          diff;
    logic                 take;
    logic [SUMW-1:0]      len_add;
    logic                 len_sat;
    t_area                area_mag;
    logic [AREA_OUT_BITS-1:0] area_clip;

    assign in_accept = i_in_valid && !o_in_stall;
    // The result register can be loaded when empty or when its result leaves now.
    assign out_free  = !r_out_valid || !i_out_stall;

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (!r_have_vertex) begin
                        n_state = i_last_vertex ? S_CLOSE : S_IDLE;
                    end else begin
                        n_state = S_SQX;
                    end
                end
            end
            S_SQX:   n_state = S_SQY;
            S_SQY:   n_state = S_TERM;
            S_TERM:  n_state = S_LOAD;
            S_LOAD:  n_state = S_ROOT;
            S_ROOT:  n_state = (r_cnt == CNT_LAST) ? S_ACC : S_ROOT;
            S_ACC:   n_state = r_cur_last ? S_CLOSE : S_IDLE;
            S_CLOSE: n_state = S_CSUM;
            S_CSUM:  n_state = S_FINAL;
            S_FINAL: n_state = out_free ? S_IDLE : S_FINAL;
            default: n_state = S_IDLE;
        endcase
    end

    // Output and datapath control logic. The multiplier operands are chosen
    // by state, so one multiplier serves both squares and both area terms.
    always_comb begin
        o_in_stall = (r_state != S_IDLE);
        mul_a      = '0;
        mul_b      = '0;
        unique case (r_state)
            S_SQX: begin
                mul_a = CW1'(r_cur_x) - CW1'(r_prev_x);
                mul_b = mul_a;
            end
            S_SQY: begin
                mul_a = CW1'(r_cur_y) - CW1'(r_prev_y);
                mul_b = mul_a;
            end
            S_TERM: begin
                // Edge term (y1 + y2) * (x2 - x1).
                mul_a = CW1'(r_prev_y) + CW1'(r_cur_y);
                mul_b = CW1'(r_cur_x) - CW1'(r_prev_x);
            end
            S_CLOSE: begin
                // Closing edge from the last vertex back to the first.
                mul_a = CW1'(r_cur_y) + CW1'(r_first_y);
                mul_b = CW1'(r_first_x) - CW1'(r_cur_x);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // One step of the restoring square root: bring down the next radicand pair
    // and try to subtract 4*root + 1.
    assign rem_sh = {r_rem[RW-3:0], r_rad[RADW-1 -: 2]};
    assign trial  = RW'({r_root, 2'b01});
    assign diff   = {1'b0, rem_sh} - {1'b0, trial};
    assign take   = !diff[RW];

    // Saturating perimeter accumulate.
    assign len_add = SUMW'(r_length_sum) + SUMW'(r_root);
    assign len_sat = (len_add >= SUMW'(LEN_MAX));

    // Magnitude of the area sum, clipped to the output width.
    assign area_mag  = r_area_sum[AREA_ACC_BITS-1] ? (~r_area_sum + t_area'(1)) : r_area_sum;
    assign area_clip = ($unsigned(area_mag) > AREA_ACC_BITS'(AREA_OUT_MAX))
                     ? AREA_OUT_MAX : area_mag[AREA_OUT_BITS-1:0];

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_have_vertex <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_accept) begin
                r_have_vertex <= 1'b1;
            end else if (r_state == S_FINAL && out_free) begin
                r_have_vertex <= 1'b0;
            end
            if (r_state == S_FINAL && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    r_cur_x    <= i_vertex_x;
                    r_cur_y    <= i_vertex_y;
                    r_cur_last <= i_last_vertex;
                    if (!r_have_vertex) begin
                        // A new polygon opens with this vertex.
                        r_first_x    <= i_vertex_x;
                        r_first_y    <= i_vertex_y;
                        r_prev_x     <= i_vertex_x;
                        r_prev_y     <= i_vertex_y;
                        r_area_sum   <= '0;
                        r_length_sum <= '0;
                    end
                end
            end
            S_SQX: begin
                r_prod <= mul_p;
            end
            S_SQY: begin
                r_prod <= mul_p;
                r_d2   <= $unsigned(r_prod);
            end
            S_TERM: begin
                r_prod <= mul_p;
                r_d2   <= r_d2 + $unsigned(r_prod);
            end
            S_LOAD: begin
                r_area_sum <= r_area_sum + t_area'(r_prod);
                r_rad      <= RADW'(r_d2) << (2 * FRACTION_BITS);
                r_root     <= '0;
                r_rem      <= '0;
                r_cnt      <= '0;
            end
            S_ROOT: begin
                r_rad <= r_rad << 2;
                r_cnt <= r_cnt + CNTW'(1);
                if (take) begin
                    r_rem  <= diff[RW-1:0];
                    r_root <= {r_root[NR-2:0], 1'b1};
                end else begin
                    r_rem  <= rem_sh;
                    r_root <= {r_root[NR-2:0], 1'b0};
                end
            end
            S_ACC: begin
                r_length_sum <= len_sat ? LEN_MAX : len_add[LEN_BITS-1:0];
                r_prev_x     <= r_cur_x;
                r_prev_y     <= r_cur_y;
            end
            S_CLOSE: begin
                r_prod <= mul_p;
            end
            S_CSUM: begin
                r_area_sum <= r_area_sum + t_area'(r_prod);
            end
            S_FINAL: begin
                if (out_free) begin
                    r_area_out <= area_clip;
                    r_len_out  <= r_length_sum;
                end
            end
            default: begin
                r_prod <= r_prod;
            end
        endcase
    end

    assign o_out_valid           = r_out_valid;
    assign o_area_doubled        = r_area_out;
    assign o_perimeter_fixed     = r_len_out;
    assign o_perimeter_saturated = (r_len_out == LEN_MAX);

endmodule

`default_nettype wire

/* rtl/core/pap_checker.sv */
// Port-level checker for the polygon area and perimeter unit, with its bind.
`default_nettype none

module pap_checker
    import pap_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input wire                         i_clk,
    input wire                         i_rst_n,
    input wire                         i_in_valid,
    input wire                         o_in_stall,
    input wire signed [COORD_BITS-1:0] i_vertex_x,
    input wire signed [COORD_BITS-1:0] i_vertex_y,
    input wire                         i_last_vertex,
    input wire                         o_out_valid,
    input wire                         i_out_stall,
    input wire [AREA_OUT_BITS-1:0]     o_area_doubled,
    input wire [LEN_BITS-1:0]          o_perimeter_fixed,
    input wire                         o_perimeter_saturated
);

    // A stalled request stays in place.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_vertex_x)
            && $stable(i_vertex_y) && $stable(i_last_vertex))
        else $error("request changed while stalled");

    // A stalled result stays in place.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_area_doubled)
            && $stable(o_perimeter_fixed) && $stable(o_perimeter_saturated))
        else $error("result changed while stalled");

    // A new result only comes out of a busy cycle of the unit.
    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without the unit having been busy");

    // The saturation flag agrees with the perimeter value.
    a_sat_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_perimeter_saturated == (o_perimeter_fixed == LEN_MAX)))
        else $error("saturation flag disagrees with perimeter");

    // A vertex that arrives while the unit is busy is not taken; once busy
    // the unit stays busy beyond its first busy state.
    a_busy_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_stall) |=> o_in_stall)
        else $error("unit became ready one cycle after going busy");

endmodule

bind polygon_area_perimeter_unit pap_checker #(
    .COORD_BITS(COORD_BITS)
) u_pap_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .i_in_valid           (i_in_valid),
    .o_in_stall           (o_in_stall),
    .i_vertex_x           (i_vertex_x),
    .i_vertex_y           (i_vertex_y),
    .i_last_vertex        (i_last_vertex),
    .o_out_valid          (o_out_valid),
    .i_out_stall          (i_out_stall),
    .o_area_doubled       (o_area_doubled),
    .o_perimeter_fixed    (o_perimeter_fixed),
    .o_perimeter_saturated(o_perimeter_saturated)
);

`default_nettype wire
